/* rtl/bc1pi_pkg.sv */
// bc1pi_pkg: shared types, mode codes and endpoint expansion helpers
// for the bc1 palette interpolator; no dependencies
package bc1pi_pkg;

  localparam int unsigned ENTRY_CNT = 4;

  localparam logic [1:0] MODE_TRUNC  = 2'd0;
  localparam logic [1:0] MODE_ROUND  = 2'd1;
  localparam logic [1:0] MODE_MUL    = 2'd2;
  localparam logic [1:0] MODE_WEIGHT = 2'd3;

  localparam logic [1:0] LAST_IDX = 2'd3;
  localparam logic [7:0] OPAQUE   = 8'hFF;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  typedef rgba_t [ENTRY_CNT-1:0] palette_t;

  function automatic logic [7:0] expand5(input logic [4:0] x);
    return {x, x[4:2]};
  endfunction

  function automatic logic [7:0] expand6(input logic [5:0] x);
    return {x, x[5:4]};
  endfunction

endpackage

/* rtl/bc1pi_blend.sv */
// bc1pi_blend: combinational palette builder from one endpoint pair
// depends on bc1pi_pkg
module bc1pi_blend (
  input  logic [15:0]        low_q,
  input  logic [15:0]        high_q,
  input  logic [1:0]         mode,
  output bc1pi_pkg::palette_t palette
);
  import bc1pi_pkg::*;

  // x / 3 for x below 768
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd683;
    return p[18:11];
  endfunction

  function automatic logic [7:0] third8(input logic [7:0] a, input logic [7:0] b,
                                        input logic [1:0] m);
    logic [9:0]  s;
    logic [13:0] w;
    logic [7:0]  res;
    s = {1'b0, a, 1'b0} + {2'b00, b};
    w = 14'(a) * 14'd43 + 14'(b) * 14'd21 + 14'd32;
    unique case (m)
      MODE_ROUND:  res = div3(s + 10'd1);
      MODE_WEIGHT: res = w[13:6];
      MODE_TRUNC:  res = div3(s);
      MODE_MUL:    res = div3(s);
    endcase
    return res;
  endfunction

  function automatic logic [7:0] half8(input logic [7:0] a, input logic [7:0] b,
                                       input logic [1:0] m);
    logic [9:0] s;
    s = {2'b00, a} + {2'b00, b} + ((m == MODE_WEIGHT) ? 10'd1 : 10'd0);
    return s[8:1];
  endfunction

  function automatic logic [7:0] third5(input logic [4:0] a, input logic [4:0] b);
    logic [11:0] p;
    p = ({6'd0, a, 1'b0} + {7'd0, b}) * 12'd22;
    return p[10:3];
  endfunction

  function automatic logic [7:0] half5(input logic [4:0] a, input logic [4:0] b);
    logic [11:0] p;
    p = ({7'd0, a} + {7'd0, b}) * 12'd33;
    return p[10:3];
  endfunction

  function automatic logic [7:0] green_mul(input logic [7:0] a, input logic [7:0] b,
                                           input logic half);
    logic signed [9:0]  d;
    logic signed [9:0]  dq;
    logic signed [17:0] num;
    d   = $signed({2'b00, b}) - $signed({2'b00, a});
    // quarter of d, truncated toward zero
    dq  = d[9] ? ((d + 10'sd3) >>> 2) : (d >>> 2);
    num = $signed({2'b00, a, 8'h00}) + 18'(dq) + 18'sd128
        + (half ? (18'(d) <<< 7) : (18'(d) * 18'sd80));
    return num[15:8];
  endfunction

  logic [4:0] r0, b0, r1, b1;
  logic [5:0] g0, g1;
  logic [7:0] rx0, gx0, bx0, rx1, gx1, bx1;
  logic       four;
  logic       mul;

  assign r0 = low_q[15:11];
  assign g0 = low_q[10:5];
  assign b0 = low_q[4:0];
  assign r1 = high_q[15:11];
  assign g1 = high_q[10:5];
  assign b1 = high_q[4:0];

  assign rx0 = expand5(r0);
  assign gx0 = expand6(g0);
  assign bx0 = expand5(b0);
  assign rx1 = expand5(r1);
  assign gx1 = expand6(g1);
  assign bx1 = expand5(b1);

  assign four = low_q > high_q;
  assign mul  = mode == MODE_MUL;

  always_comb begin
    palette[0] = '{red: rx0, green: gx0, blue: bx0, alpha: OPAQUE};
    palette[1] = '{red: rx1, green: gx1, blue: bx1, alpha: OPAQUE};
    if (four) begin
      if (mul) begin
        palette[2] = '{red: third5(r0, r1), green: green_mul(gx0, gx1, 1'b0),
                       blue: third5(b0, b1), alpha: OPAQUE};
        palette[3] = '{red: third5(r1, r0), green: green_mul(gx1, gx0, 1'b0),
                       blue: third5(b1, b0), alpha: OPAQUE};
      end else begin
        palette[2] = '{red: third8(rx0, rx1, mode), green: third8(gx0, gx1, mode),
                       blue: third8(bx0, bx1, mode), alpha: OPAQUE};
        palette[3] = '{red: third8(rx1, rx0, mode), green: third8(gx1, gx0, mode),
                       blue: third8(bx1, bx0, mode), alpha: OPAQUE};
      end
    end else begin
      if (mul) begin
        palette[2] = '{red: half5(r0, r1), green: green_mul(gx0, gx1, 1'b1),
                       blue: half5(b0, b1), alpha: OPAQUE};
      end else begin
        palette[2] = '{red: half8(rx0, rx1, mode), green: half8(gx0, gx1, mode),
                       blue: half8(bx0, bx1, mode), alpha: OPAQUE};
      end
      // transparent black
      palette[3] = '0;
    end
  end

endmodule

/* rtl/bc1pi_emitter.sv */
// bc1pi_emitter: palette register and entry counter, one entry per cycle
// depends on bc1pi_pkg
module bc1pi_emitter (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  bc1pi_pkg::palette_t palette_in,
  output logic                free,
  output logic                result_valid,
  output logic [1:0]          entry_index,
  output logic [7:0]          red,
  output logic [7:0]          green,
  output logic [7:0]          blue,
  output logic [7:0]          alpha,
  output logic                last_entry
);
  import bc1pi_pkg::*;

  palette_t   palette;
  logic [1:0] cnt;
  logic       emit_valid;

  assign free = !emit_valid || (cnt == LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_valid <= 1'b0;
      cnt        <= '0;
    end else if (load) begin
      emit_valid <= 1'b1;
      cnt        <= '0;
    end else if (emit_valid) begin
      cnt        <= cnt + 2'd1;
      emit_valid <= cnt != LAST_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      palette <= palette_in;
    end
  end

  assign result_valid = emit_valid;
  assign entry_index  = cnt;
  assign red          = palette[cnt].red;
  assign green        = palette[cnt].green;
  assign blue         = palette[cnt].blue;
  assign alpha        = palette[cnt].alpha;
  assign last_entry   = cnt == LAST_IDX;

endmodule

/* rtl/bc1_palette_interpolator_top.sv */
// Each endpoint pair accepted on start gives four palette entries on
// consecutive cycles, entry 0 first, marked by result_valid; the pair passes
// the input register, then the blend logic into the emitter's palette
// register, loaded once the emitter is free. One pair waits in the input
// register while the previous palette drains, so results run without gaps.
// The receiver cannot stall: every result_valid cycle must be taken.
// top level: input register, blend logic and emitter; depends on bc1pi_pkg
module bc1_palette_interpolator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] low_endpoint,
  input  logic [15:0] high_endpoint,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  output logic        result_valid,
  output logic [1:0]  entry_index,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic        last_entry
);
  import bc1pi_pkg::*;

  logic       in_valid;
  logic       in_valid_next;
  logic [15:0] low_q;
  logic [15:0] high_q;
  logic [1:0] blend_mode;
  logic       free;
  logic       load;
  logic       accept;
  palette_t   palette;

  assign load   = in_valid && free;
  assign busy   = in_valid && !free;
  assign accept = start && !busy;

  always_comb begin
    in_valid_next = in_valid;
    if (accept) begin
      in_valid_next = 1'b1;
    end else if (load) begin
      in_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      blend_mode <= MODE_TRUNC;
    end else begin
      in_valid <= in_valid_next;
      if (cfg_wr_en) begin
        blend_mode <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      low_q  <= low_endpoint;
      high_q <= high_endpoint;
    end
  end

  bc1pi_blend u_blend (
    .low_q   (low_q),
    .high_q  (high_q),
    .mode    (blend_mode),
    .palette (palette)
  );

  bc1pi_emitter u_emitter (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .palette_in   (palette),
    .free         (free),
    .result_valid (result_valid),
    .entry_index  (entry_index),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .last_entry   (last_entry)
  );

  // entries of one palette come in order without gaps
  a_entry_order: assert property (@(posedge clk) disable iff (rst)
    (result_valid && entry_index != 2'd0) |->
      ($past(result_valid) && ($past(entry_index) + 2'd1 == entry_index)))
    else $error("palette entry out of order");

  // a waiting pair starts right after the last entry
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_entry && in_valid) |=>
      (result_valid && entry_index == 2'd0))
    else $error("gap between palettes");

  // an accepted item is held in the input register
  a_accept_held: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> in_valid)
    else $error("accepted item lost");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result after reset");

endmodule
